### hdl/ssfb_pkg.sv
// shared types and constants for the seven-segment frame builder
// no dependencies
package ssfb_pkg;

   localparam int unsigned NUM_DIGITS = 8;
   localparam int unsigned CODE_W     = 5;
   localparam int unsigned SLOT_W     = 5;

   typedef struct packed {
      logic [4:0] code_0;
      logic [4:0] code_1;
      logic [4:0] code_2;
      logic [4:0] code_3;
      logic [4:0] code_4;
      logic [4:0] code_5;
      logic [4:0] code_6;
      logic [4:0] code_7;
      logic       point_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       strobe_begin;
      logic       strobe_end;
      logic       last;
   } rsp_type;

   typedef logic [NUM_DIGITS-1:0][7:0] data_bytes_type;

   localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
   localparam logic [7:0] CMD_DATA_MODE  = 8'h40;
   localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
   localparam logic [7:0] LED_FIRST      = 8'h80;
   localparam logic [7:0] LED_OFF        = 8'h00;
   localparam logic [7:0] SEG_POINT      = 8'h80;

   localparam logic [SLOT_W-1:0] SLOT_DISPLAY_ON = 5'd0;
   localparam logic [SLOT_W-1:0] SLOT_DATA_MODE  = 5'd1;
   localparam logic [SLOT_W-1:0] SLOT_ADDRESS    = 5'd2;
   localparam logic [SLOT_W-1:0] SLOT_FIRST_DATA = 5'd3;
   localparam logic [SLOT_W-1:0] SLOT_LAST       = 5'd18;

   localparam logic [31:0][7:0] SEG_TABLE = {
      8'h3E, 8'h79, 8'h76, 8'h38, 8'h1C, 8'h5C, 8'h5E, 8'h30,
      8'h73, 8'h50, 8'h6E, 8'h54, 8'h38, 8'h74, 8'h50, 8'h40,
      8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
      8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
   };

endpackage

### hdl/seven_segment_frame_builder_core.sv
// Each accepted transaction yields a 19-byte display frame, sent one byte per clock cycle
// over the single byte-wide result port. start is taken again during the cycle that selects
// the last byte, so frames follow with no gap. The first byte passes through the slot counter
// and then the result register before it reaches the result ports. The receiver cannot
// stall: every byte is valid for exactly one cycle while rsp_strobe is high. csr_ready stays
// low while a frame is in flight or start is high, so brightness only changes between
// frames.
// depends on ssfb_pkg, ssfb_encode, ssfb_frame_seq
module seven_segment_frame_builder_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssfb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ssfb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_data
);

   logic [2:0]               brightness_val_ff;
   logic                     load;
   ssfb_pkg::data_bytes_type data_bytes;

   assign csr_ready = !busy && !rsp_strobe && !start;
   assign load      = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_val_ff <= 3'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            brightness_val_ff <= csr_data;
         end
      end
   end

   ssfb_encode u_encode (
      .req        (req_data),
      .data_bytes (data_bytes)
   );

   ssfb_frame_seq u_frame_seq (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .data_bytes (data_bytes),
      .brightness (brightness_val_ff),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### hdl/ssfb_encode.sv
// segment lookup, decimal point insertion and bit transpose into data bytes
// depends on ssfb_pkg
module ssfb_encode (
   input  ssfb_pkg::req_type        req,
   output ssfb_pkg::data_bytes_type data_bytes
);

   logic [ssfb_pkg::NUM_DIGITS-1:0][ssfb_pkg::CODE_W-1:0] codes;
   logic [ssfb_pkg::NUM_DIGITS-1:0][7:0]                  pat;

   assign codes[0] = req.code_0;
   assign codes[1] = req.code_1;
   assign codes[2] = req.code_2;
   assign codes[3] = req.code_3;
   assign codes[4] = req.code_4;
   assign codes[5] = req.code_5;
   assign codes[6] = req.code_6;
   assign codes[7] = req.code_7;

   always_comb begin
      for (int p = 0; p < ssfb_pkg::NUM_DIGITS; p++) begin
         pat[p] = ssfb_pkg::SEG_TABLE[codes[p]];
         if (req.point_mode && (p == 2 || p == 6)) begin
            pat[p] = pat[p] | ssfb_pkg::SEG_POINT;
         end
      end
   end

   // byte k carries bit k of each pattern, bit j from digit 7-j
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         for (int j = 0; j < ssfb_pkg::NUM_DIGITS; j++) begin
            data_bytes[k][j] = pat[ssfb_pkg::NUM_DIGITS-1-j][k];
         end
      end
   end

endmodule

### hdl/ssfb_frame_seq.sv
// frame register, slot counter and result register emitting one byte a cycle
// depends on ssfb_pkg
module ssfb_frame_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  ssfb_pkg::data_bytes_type data_bytes,
   input  logic [2:0]               brightness,
   output logic                     busy,
   output logic                     rsp_strobe,
   output ssfb_pkg::rsp_type        rsp_data
);

   ssfb_pkg::data_bytes_type       data_ff;
   logic [ssfb_pkg::SLOT_W-1:0]    slot_ff;
   logic                           active_ff;
   logic                           strobe_ff;
   ssfb_pkg::rsp_type              rsp_ff;
   ssfb_pkg::rsp_type              rsp_in;
   logic [ssfb_pkg::SLOT_W-1:0]    data_slot;
   logic [2:0]                     pair;

   assign data_slot = slot_ff - ssfb_pkg::SLOT_FIRST_DATA;
   assign pair      = data_slot[3:1];

   always_comb begin
      rsp_in.out_byte     = ssfb_pkg::LED_OFF;
      rsp_in.strobe_begin = 1'b0;
      rsp_in.strobe_end   = 1'b0;
      rsp_in.last         = 1'b0;
      if (slot_ff == ssfb_pkg::SLOT_DISPLAY_ON) begin
         rsp_in.out_byte     = ssfb_pkg::CMD_DISPLAY_ON | {5'd0, brightness};
         rsp_in.strobe_begin = 1'b1;
         rsp_in.strobe_end   = 1'b1;
      end else if (slot_ff == ssfb_pkg::SLOT_DATA_MODE) begin
         rsp_in.out_byte     = ssfb_pkg::CMD_DATA_MODE;
         rsp_in.strobe_begin = 1'b1;
         rsp_in.strobe_end   = 1'b1;
      end else if (slot_ff == ssfb_pkg::SLOT_ADDRESS) begin
         rsp_in.out_byte     = ssfb_pkg::CMD_ADDRESS;
         rsp_in.strobe_begin = 1'b1;
      end else if (!data_slot[0]) begin
         rsp_in.out_byte = data_ff[pair];
      end else begin
         rsp_in.out_byte   = (pair == 3'd0) ? ssfb_pkg::LED_FIRST : ssfb_pkg::LED_OFF;
         rsp_in.strobe_end = (slot_ff == ssfb_pkg::SLOT_LAST);
         rsp_in.last       = (slot_ff == ssfb_pkg::SLOT_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         slot_ff   <= ssfb_pkg::SLOT_DISPLAY_ON;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= active_ff;
         if (load) begin
            active_ff <= 1'b1;
            slot_ff   <= ssfb_pkg::SLOT_DISPLAY_ON;
         end else if (active_ff) begin
            if (slot_ff == ssfb_pkg::SLOT_LAST) begin
               active_ff <= 1'b0;
            end else begin
               slot_ff <= slot_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (load) begin
         data_ff <= data_bytes;
      end
   end

   // next transaction may enter while the final byte of a frame is selected
   assign busy       = active_ff && (slot_ff != ssfb_pkg::SLOT_LAST);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
